// ===== rtl/cbe_pkg.sv =====
// Package: constants, types and helpers shared by the cubic Bezier easing block.
`default_nettype none
package cbe_pkg;

  // Fixed-point format and iteration limits
  localparam int FRAC_BITS     = 16;
  localparam int NEWTON_STEPS  = 8;
  localparam int BISECT_STEPS  = 20;
  localparam int TOLERANCE_LSB = 4;

  // Field widths
  localparam int VAL_W = 32;
  localparam int WGT_W = 18;
  localparam int AX1_W = 16;
  localparam int AY_W  = 19;
  localparam int AX2_W = 17;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Datapath widths
  localparam int T_W    = FRAC_BITS + 3;          // curve parameter, -1..2
  localparam int CO_W   = FRAC_BITS + 10;         // curve coefficients
  localparam int ACC_W  = 2 * FRAC_BITS + 16;     // accumulator
  localparam int A_W    = 34;                     // multiplier operand A
  localparam int B_W    = T_W;                    // multiplier operand B
  localparam int P_W    = A_W + B_W;              // product
  localparam int DIFF_W = VAL_W + 1;              // end - start
  localparam int DIV_W  = 2 * FRAC_BITS + 10;     // divider magnitude
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam int NCNT_W = $clog2(NEWTON_STEPS + 1);
  localparam int BCNT_W = $clog2(BISECT_STEPS + 1);

  localparam logic signed [ACC_W-1:0] ONE_A = ACC_W'(1) <<< FRAC_BITS;
  localparam logic signed [ACC_W-1:0] TOL_A = ACC_W'(TOLERANCE_LSB);
  localparam logic signed [ACC_W-1:0] VMAX_A = ACC_W'(2147483647);
  localparam logic signed [ACC_W-1:0] VMIN_A = -ACC_W'(2147483647) - ACC_W'(1);

  // Register reset values
  localparam logic [AX1_W-1:0] AX1_RST = AX1_W'(39322);
  localparam logic [AY_W-1:0]  AY1_RST = AY_W'(0);
  localparam logic [AX2_W-1:0] AX2_RST = AX2_W'(45875);
  localparam logic [AY_W-1:0]  AY2_RST = AY_W'(65536);

  // Register indexes
  typedef enum logic [1:0] {
    REG_AX1 = 2'd0,
    REG_AY1 = 2'd1,
    REG_AX2 = 2'd2,
    REG_AY2 = 2'd3
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_EVAL,
    ST_DIV,
    ST_OUT
  } state_e;

  // What the shared multiplier is working on
  typedef enum logic [2:0] {
    PH_NX,   // x(t) for Newton
    PH_ND,   // x'(t) for Newton
    PH_BX,   // x(t) for bisection
    PH_Y,    // y(t)
    PH_LO,   // (end-start) * low part of y
    PH_HI    // (end-start) * high part of y
  } phase_e;

  typedef struct packed {
    logic [AX1_W-1:0] ax1;
    logic [AY_W-1:0]  ay1;
    logic [AX2_W-1:0] ax2;
    logic [AY_W-1:0]  ay2;
  } cfg_t;

  typedef struct packed {
    logic signed [CO_W-1:0] a;
    logic signed [CO_W-1:0] b;
    logic signed [CO_W-1:0] c;
  } coeff_t;

  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] dividend;
    logic signed [ACC_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] quo;
  } div_rsp_t;

  // c = 3*p1, b = 3*(p2-p1) - c, a = 1 - c - b
  function automatic coeff_t make_coeffs(input logic signed [CO_W-1:0] p1,
                                         input logic signed [CO_W-1:0] p2);
    coeff_t k;
    k.c = p1 + (p1 <<< 1);
    k.b = (p2 - p1) + ((p2 - p1) <<< 1) - k.c;
    k.a = (CO_W'(1) <<< FRAC_BITS) - k.c - k.b;
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cubic_bezier_easing_top.sv =====
// Cubic Bezier easing: sequencer around a shared multiplier and a serial divider.
//
// Eases between start_value and end_value along a cubic Bezier timing curve
// whose inner anchors come from the APB registers. One transaction is worked
// on at a time; in_stall_o is high while it runs. A weight at or below 0 or at
// or above 1 gives start_value or end_value without evaluating the curve.
// Otherwise each curve sample and each slope is worked out by Horner steps on
// the one shared multiplier, and each Newton quotient by the bit-serial
// divider; a Newton step takes a sample, a slope and a quotient, a bisection
// probe one sample. An item may end in the first Newton probe; in the worst
// case it runs 8 Newton steps and then 20 bisection probes. A finished result
// waits in the output register while the next transaction is accepted.
`default_nettype none
module cubic_bezier_easing_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic        [cbe_pkg::ADDR_W-1:0]  paddr,
  input  wire logic        [cbe_pkg::DATA_W-1:0]  pwdata,
  output logic             [cbe_pkg::DATA_W-1:0]  prdata,
  output logic                                    pready,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [cbe_pkg::VAL_W-1:0]   start_value_i,
  input  wire logic signed [cbe_pkg::VAL_W-1:0]   end_value_i,
  input  wire logic signed [cbe_pkg::WGT_W-1:0]   weight_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed      [cbe_pkg::VAL_W-1:0]   eased_value_o
);
  import cbe_pkg::*;

  cfg_t     cfg;
  coeff_t   kx, ky;
  div_req_t div_req;
  div_rsp_t div_rsp;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [1:0]        step_q, step_d;
  logic [NCNT_W-1:0] ncnt_q, ncnt_d;
  logic [BCNT_W-1:0] bcnt_q, bcnt_d;
  logic              out_valid_q, out_valid_d;

  logic signed [ACC_W-1:0]  acc_q, acc_d, xerr_q, xerr_d, y_q, y_d;
  logic signed [T_W-1:0]    t_q, t_d, t0_q, t0_d, t1_q, t1_d;
  logic signed [VAL_W-1:0]  start_q, start_d, res_q, res_d, eased_q, eased_d;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic signed [WGT_W-1:0]  w_q, w_d;

  logic                    mul_en;
  logic signed [A_W-1:0]   mul_a;
  logic signed [B_W-1:0]   mul_b;
  logic signed [P_W-1:0]   prod;
  logic signed [ACC_W-1:0] addend;

  localparam logic signed [T_W-1:0] ONE_T = T_W'(1) <<< FRAC_BITS;

  cbe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cbe_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  cbe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // curve coefficients; the user must keep them static while a transaction runs, the block does not enforce it
  assign kx = make_coeffs($signed(CO_W'(cfg.ax1)), $signed(CO_W'(cfg.ax2)));
  assign ky = make_coeffs(CO_W'($signed(cfg.ay1)), CO_W'($signed(cfg.ay2)));

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign eased_value_o = eased_q;

  // multiplier operands
  always_comb begin
    mul_en = (state_q == ST_MUL);
    case (phase_q)
      PH_LO: begin
        mul_a = A_W'(diff_q);
        mul_b = $signed(B_W'(y_q[FRAC_BITS-1:0]));
      end
      PH_HI: begin
        mul_a = A_W'(diff_q);
        mul_b = B_W'(y_q >>> FRAC_BITS);
      end
      default: begin
        mul_a = $signed(acc_q[A_W-1:0]);
        mul_b = t_q;
      end
    endcase
  end

  // Horner addend for each step
  always_comb begin
    case (phase_q)
      PH_NX, PH_BX: begin
        case (step_q)
          2'd0:    addend = ACC_W'(kx.b);
          2'd1:    addend = ACC_W'(kx.c);
          default: addend = '0;
        endcase
      end
      PH_ND: begin
        case (step_q)
          2'd1:    addend = ACC_W'(kx.b) <<< 1;
          default: addend = ACC_W'(kx.c);
        endcase
      end
      PH_Y: begin
        case (step_q)
          2'd0:    addend = ACC_W'(ky.b);
          2'd1:    addend = ACC_W'(ky.c);
          default: addend = '0;
        endcase
      end
      default: addend = '0;
    endcase
  end

  // sequencer
  always_comb begin
    logic signed [ACC_W-1:0] w_ext, xe, tn, sum;
    logic signed [T_W-1:0]   t0n, t1n, tb;
    logic signed [T_W:0]     half;
    logic [BCNT_W-1:0]       bn;

    state_d     = state_q;
    phase_d     = phase_q;
    step_d      = step_q;
    ncnt_d      = ncnt_q;
    bcnt_d      = bcnt_q;
    acc_d       = acc_q;
    xerr_d      = xerr_q;
    y_d         = y_q;
    t_d         = t_q;
    t0_d        = t0_q;
    t1_d        = t1_q;
    start_d     = start_q;
    diff_d      = diff_q;
    w_d         = w_q;
    res_d       = res_q;
    eased_d     = eased_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_req.start    = 1'b0;
    div_req.dividend = xerr_q <<< FRAC_BITS;
    div_req.divisor  = acc_q;

    w_ext = ACC_W'(w_q);
    xe    = acc_q - w_ext;
    tn    = ACC_W'(t_q) - div_rsp.quo;
    sum   = '0;
    t0n   = t0_q;
    t1n   = t1_q;
    half  = '0;
    tb    = t_q;
    bn    = bcnt_q + BCNT_W'(1);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          start_d = start_value_i;
          diff_d  = DIFF_W'(end_value_i) - DIFF_W'(start_value_i);
          w_d     = weight_i;
          if (weight_i[WGT_W-1] || (weight_i == '0)) begin
            res_d   = start_value_i;
            state_d = ST_OUT;
          end else if (ACC_W'(weight_i) >= ONE_A) begin
            res_d   = end_value_i;
            state_d = ST_OUT;
          end else begin
            t_d     = T_W'(weight_i);
            ncnt_d  = '0;
            acc_d   = ACC_W'(kx.a);
            step_d  = 2'd0;
            phase_d = PH_NX;
            state_d = ST_MUL;
          end
        end
      end

      ST_MUL: state_d = ST_ADD;

      ST_ADD: begin
        case (phase_q)
          PH_LO: begin
            acc_d   = ACC_W'(prod >>> FRAC_BITS);
            phase_d = PH_HI;
            state_d = ST_MUL;
          end
          PH_HI: begin
            sum = acc_q + ACC_W'(prod) + ACC_W'(start_q);
            if (sum > VMAX_A)      res_d = VAL_W'(VMAX_A);
            else if (sum < VMIN_A) res_d = VAL_W'(VMIN_A);
            else                   res_d = VAL_W'(sum);
            state_d = ST_OUT;
          end
          default: begin
            acc_d = ACC_W'(prod >>> FRAC_BITS) + addend;
            if (step_q == 2'd2) begin
              state_d = ST_EVAL;
            end else begin
              step_d  = step_q + 2'd1;
              state_d = ST_MUL;
            end
          end
        endcase
      end

      ST_EVAL: begin
        case (phase_q)
          PH_NX: begin
            if (xe < TOL_A && xe > -TOL_A) begin
              acc_d   = ACC_W'(ky.a);
              step_d  = 2'd0;
              phase_d = PH_Y;
              state_d = ST_MUL;
            end else begin
              xerr_d  = xe;
              acc_d   = ACC_W'(kx.a) + (ACC_W'(kx.a) <<< 1);
              step_d  = 2'd1;
              phase_d = PH_ND;
              state_d = ST_MUL;
            end
          end
          PH_ND: begin
            if (acc_q < TOL_A && acc_q > -TOL_A) begin
              // flat slope: fall back to bisection
              t0_d    = '0;
              t1_d    = ONE_T;
              t_d     = T_W'(w_q);
              bcnt_d  = '0;
              acc_d   = ACC_W'(kx.a);
              step_d  = 2'd0;
              phase_d = PH_BX;
              state_d = ST_MUL;
            end else begin
              div_req.start = 1'b1;
              state_d       = ST_DIV;
            end
          end
          PH_BX: begin
            if (xe < TOL_A && xe > -TOL_A) begin
              acc_d   = ACC_W'(ky.a);
              step_d  = 2'd0;
              phase_d = PH_Y;
              state_d = ST_MUL;
            end else begin
              if (w_ext > acc_q) t0n = t_q;
              else               t1n = t_q;
              half   = ((T_W+1)'(t1n) - (T_W+1)'(t0n)) >>> 1;
              tb     = t0n + T_W'(half);
              t0_d   = t0n;
              t1_d   = t1n;
              t_d    = tb;
              bcnt_d = bn;
              acc_d  = ACC_W'(kx.a);
              step_d = 2'd0;
              if (bn < BCNT_W'(BISECT_STEPS) && t0n < t1n) begin
                phase_d = PH_BX;
              end else begin
                acc_d   = ACC_W'(ky.a);
                phase_d = PH_Y;
              end
              state_d = ST_MUL;
            end
          end
          PH_Y: begin
            y_d     = acc_q;
            phase_d = PH_LO;
            state_d = ST_MUL;
          end
          default: state_d = ST_IDLE;
        endcase
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          // Newton update with runaway clamp
          if (tn < -ONE_A)               t_d = -ONE_T;
          else if (tn > (ONE_A <<< 1))   t_d = ONE_T <<< 1;
          else                           t_d = T_W'(tn);
          ncnt_d = ncnt_q + NCNT_W'(1);
          acc_d  = ACC_W'(kx.a);
          step_d = 2'd0;
          if (ncnt_q + NCNT_W'(1) == NCNT_W'(NEWTON_STEPS)) begin
            t0_d    = '0;
            t1_d    = ONE_T;
            t_d     = T_W'(w_q);
            bcnt_d  = '0;
            phase_d = PH_BX;
          end else begin
            phase_d = PH_NX;
          end
          state_d = ST_MUL;
        end
      end

      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          eased_d     = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_NX;
      step_q      <= '0;
      ncnt_q      <= '0;
      bcnt_q      <= '0;
      out_valid_q <= 1'b0;
      t_q         <= '0;
      t0_q        <= '0;
      t1_q        <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      ncnt_q      <= ncnt_d;
      bcnt_q      <= bcnt_d;
      out_valid_q <= out_valid_d;
      t_q         <= t_d;
      t0_q        <= t0_d;
      t1_q        <= t1_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    xerr_q  <= xerr_d;
    y_q     <= y_d;
    start_q <= start_d;
    diff_q  <= diff_d;
    w_q     <= w_d;
    res_q   <= res_d;
    eased_q <= eased_d;
  end

`ifndef ASSERT_OFF
  // curve parameter stays inside the Newton clamp window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (t_q >= -ONE_T) && (t_q <= (ONE_T <<< 1)))
    else $error("curve parameter outside clamp window");

  // bisection interval stays ordered inside [0,1]
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && phase_q == PH_BX) |->
      (t0_q <= t1_q) && (t0_q >= '0) && (t1_q <= ONE_T))
    else $error("bisection interval broken");

  // Newton step count never reaches its cap while Newton runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && (phase_q == PH_NX || phase_q == PH_ND)) |->
      (ncnt_q < NCNT_W'(NEWTON_STEPS)))
    else $error("Newton step count overrun");
`endif

endmodule
`default_nettype wire

// ===== rtl/cbe_regs.sv =====
// APB configuration registers holding the two inner curve anchors.
`default_nettype none
module cbe_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cbe_pkg::ADDR_W-1:0] paddr,
  input  wire logic [cbe_pkg::DATA_W-1:0] pwdata,
  output logic      [cbe_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output cbe_pkg::cfg_t                   cfg_o
);
  import cbe_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ax1 <= AX1_RST;
      cfg_q.ay1 <= AY1_RST;
      cfg_q.ax2 <= AX2_RST;
      cfg_q.ay2 <= AY2_RST;
    end else if (wr_en) begin
      case (idx)
        REG_AX1: cfg_q.ax1 <= pwdata[AX1_W-1:0];
        REG_AY1: cfg_q.ay1 <= pwdata[AY_W-1:0];
        REG_AX2: cfg_q.ax2 <= pwdata[AX2_W-1:0];
        REG_AY2: cfg_q.ay2 <= pwdata[AY_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_AX1: prdata = DATA_W'(cfg_q.ax1);
      REG_AY1: prdata = DATA_W'(cfg_q.ay1);
      REG_AX2: prdata = DATA_W'(cfg_q.ax2);
      REG_AY2: prdata = DATA_W'(cfg_q.ay2);
      default: prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/cbe_mul.sv =====
// Shared signed multiplier with a registered product.
`default_nettype none
module cbe_mul (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic signed [cbe_pkg::A_W-1:0] a_i,
  input  wire logic signed [cbe_pkg::B_W-1:0] b_i,
  output logic signed      [cbe_pkg::P_W-1:0] prod_o
);
  import cbe_pkg::*;

  logic signed [P_W-1:0] prod_q;

  assign prod_o = prod_q;

  // product register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= P_W'(a_i) * P_W'(b_i);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cbe_div.sv =====
// Radix-2 restoring divider, signed, quotient truncated toward zero.
`default_nettype none
module cbe_div (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  cbe_pkg::div_req_t req_i,
  output cbe_pkg::div_rsp_t rsp_o
);
  import cbe_pkg::*;

  logic              busy_q, done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]  num_q, den_q;
  logic [DIV_W:0]    rem_q;
  logic              neg_q;

  logic signed [ACC_W-1:0] dd_abs, dv_abs;
  logic [DIV_W:0]          rem_sh, trial;

  assign dd_abs = req_i.dividend[ACC_W-1] ? -req_i.dividend : req_i.dividend;
  assign dv_abs = req_i.divisor[ACC_W-1]  ? -req_i.divisor  : req_i.divisor;
  assign rem_sh = {rem_q[DIV_W-1:0], num_q[DIV_W-1]};
  assign trial  = rem_sh - {1'b0, den_q};

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? -$signed({{(ACC_W-DIV_W){1'b0}}, num_q})
                            :  $signed({{(ACC_W-DIV_W){1'b0}}, num_q});

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DCNT_W'(1);
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle while busy
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= dd_abs[DIV_W-1:0];
      den_q <= dv_abs[DIV_W-1:0];
      rem_q <= '0;
      neg_q <= req_i.dividend[ACC_W-1] ^ req_i.divisor[ACC_W-1];
    end else if (busy_q) begin
      if (!trial[DIV_W]) begin
        rem_q <= trial;
        num_q <= {num_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        num_q <= {num_q[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire
